@@ src/bpa_pkg.sv @@
`default_nettype none

package bpa_pkg;

  localparam int unsigned NUM_PAGES  = 65536;
  localparam int unsigned TOP_ORDER  = 10;
  localparam int unsigned PAGE_W     = $clog2(NUM_PAGES);
  localparam int unsigned LINK_W     = PAGE_W + 1;
  localparam int unsigned SPAN_W     = PAGE_W + 2;
  localparam int unsigned ORD_W      = 4;
  localparam int unsigned NUM_LISTS  = 2 * (TOP_ORDER + 1);
  localparam int unsigned LIST_W     = $clog2(NUM_LISTS);
  localparam int unsigned CFG_W      = 17;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [CFG_W-1:0]  LZ_END_RESET = CFG_W'(4096);
  localparam logic [LINK_W-1:0] LINK_NONE    = '1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_BADORD = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLEAR,
    OP_LOAD,
    OP_SPAN0,
    OP_SPAN1,
    OP_BLK,
    OP_PG_RD,
    OP_PG_WR,
    OP_NXT,
    OP_PUSH_A,
    OP_PUSH_B,
    OP_SRCH,
    OP_AL_RD,
    OP_UNL_P,
    OP_SPLIT,
    OP_AL_FIN,
    OP_FR_RD,
    OP_FR_INIT,
    OP_RD_B,
    OP_MERGE,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_BAD,
    RES_OOM,
    RES_ALLOC,
    RES_ORD
  } res_e;

  typedef struct packed {
    op_e  op;
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic blk_more;
    logic pg_last;
    logic rd_free;
    logic srch_hit;
    logic req_bad;
    logic split_more;
    logic loop_more;
    logic merge_ok;
    logic out_free;
    logic region_free;
    logic page_oob;
  } stat_t;

  function automatic logic [LIST_W-1:0] list_of(input logic zone, input logic [ORD_W-1:0] k);
    logic [LIST_W-1:0] idx;
    idx = zone ? (LIST_W'(TOP_ORDER + 1) + LIST_W'(k)) : LIST_W'(k);
    return idx;
  endfunction

  function automatic logic link_ok(input logic [LINK_W-1:0] l);
    return l < LINK_W'(NUM_PAGES);
  endfunction

endpackage

`default_nettype wire

@@ src/buddy_page_allocator_unit.sv @@
// Buddy page allocator: one item at a time, one result beat per item.
// Alloc: search, head read, unlink, split and push per level; free: read, merge loop, push.
// Region add: every page read then written; free blocks pushed (page table port bound).
// The input side is freed by the same update that loads the result register.
// Reset: async active low; then a sweep over all 65536 pages clears the free flags.
`default_nettype none

module buddy_page_allocator_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input beats
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [15:0] page_number, [32:16] region_pages, [33] region_is_free,
  // [37:34] request_order, [38] use_low_zone, [39] zero
  input  wire logic [bpa_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // [1:0] mode
  input  wire logic [bpa_pkg::MODE_W-1:0]        s_axis_tuser,
  // result beats
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [15:0] block_page, [19:16] block_order, [23:20] zero
  output logic [bpa_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
  // [1:0] status
  output logic [bpa_pkg::STATUS_W-1:0]           m_axis_tuser,
  // low_zone_end_page write
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [bpa_pkg::CFG_W-1:0]         cfg_data_i
);
  import bpa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // register write always taken; the user must write it only while idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  // sequencer: walks the free lists and page table one step at a time
  bpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // page table memories, list heads, result register
  bpa_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (s_axis_tdata),
    .in_mode_i   (s_axis_tuser),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

endmodule

`default_nettype wire

@@ src/bpa_ctrl.sv @@
`default_nettype none

module bpa_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [bpa_pkg::MODE_W-1:0]  in_mode_i,
  output logic                             in_ready_o,
  input  wire bpa_pkg::stat_t              stat_i,
  output bpa_pkg::cmd_t                    cmd_o
);
  import bpa_pkg::*;

  localparam logic [4:0] S_CLEAR   = 5'd0;
  localparam logic [4:0] S_IDLE    = 5'd1;
  localparam logic [4:0] S_SPAN0   = 5'd2;
  localparam logic [4:0] S_SPAN1   = 5'd3;
  localparam logic [4:0] S_BLK     = 5'd4;
  localparam logic [4:0] S_PG_RD   = 5'd5;
  localparam logic [4:0] S_PG_WR   = 5'd6;
  localparam logic [4:0] S_NXT     = 5'd7;
  localparam logic [4:0] S_PUSH_A  = 5'd8;
  localparam logic [4:0] S_PUSH_B  = 5'd9;
  localparam logic [4:0] S_AL_SRCH = 5'd10;
  localparam logic [4:0] S_AL_RD   = 5'd11;
  localparam logic [4:0] S_AL_UNL  = 5'd12;
  localparam logic [4:0] S_AL_SPL  = 5'd13;
  localparam logic [4:0] S_FR_RD   = 5'd14;
  localparam logic [4:0] S_FR_CHK  = 5'd15;
  localparam logic [4:0] S_FR_LOOP = 5'd16;
  localparam logic [4:0] S_FR_BUD  = 5'd17;
  localparam logic [4:0] S_RES     = 5'd18;

  logic [4:0] state_q, state_d;
  logic       span_q, span_d;
  res_e       res_q, res_d;
  mode_e      mode_q, mode_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    span_d     = span_q;
    res_d      = res_q;
    mode_d     = mode_q;
    cmd_o.op   = OP_NOP;
    cmd_o.res  = res_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          unique case (in_mode_i)
            MODE_ADD: begin
              mode_d  = MODE_ADD;
              span_d  = 1'b0;
              state_d = S_SPAN0;
            end
            MODE_ALLOC: begin
              mode_d  = MODE_ALLOC;
              state_d = S_AL_SRCH;
            end
            MODE_FREE: begin
              mode_d  = MODE_FREE;
              state_d = S_FR_RD;
            end
            default: begin
              res_d   = RES_ZERO;
              state_d = S_RES;
            end
          endcase
        end
      end
      S_SPAN0: begin
        cmd_o.op = OP_SPAN0;
        state_d  = S_BLK;
      end
      S_SPAN1: begin
        cmd_o.op = OP_SPAN1;
        span_d   = 1'b1;
        state_d  = S_BLK;
      end
      S_BLK: begin
        if (stat_i.blk_more) begin
          cmd_o.op = OP_BLK;
          state_d  = S_PG_RD;
        end else if (!span_q) begin
          state_d = S_SPAN1;
        end else begin
          res_d   = RES_ZERO;
          state_d = S_RES;
        end
      end
      S_PG_RD: begin
        cmd_o.op = OP_PG_RD;
        state_d  = S_PG_WR;
      end
      S_PG_WR: begin
        cmd_o.op = OP_PG_WR;
        if (!stat_i.pg_last)         state_d = S_PG_RD;
        else if (stat_i.region_free) state_d = S_PUSH_A;
        else                         state_d = S_NXT;
      end
      S_NXT: begin
        cmd_o.op = OP_NXT;
        state_d  = S_BLK;
      end
      S_PUSH_A: begin
        cmd_o.op = OP_PUSH_A;
        state_d  = S_PUSH_B;
      end
      S_PUSH_B: begin
        cmd_o.op = OP_PUSH_B;
        unique case (mode_q)
          MODE_ADD:   state_d = S_NXT;
          MODE_ALLOC: state_d = S_AL_SPL;
          default: begin
            res_d   = RES_ORD;
            state_d = S_RES;
          end
        endcase
      end
      S_AL_SRCH: begin
        cmd_o.op = OP_SRCH;
        priority if (stat_i.req_bad) begin
          res_d   = RES_BAD;
          state_d = S_RES;
        end else if (!stat_i.srch_hit) begin
          res_d   = RES_OOM;
          state_d = S_RES;
        end else begin
          state_d = S_AL_RD;
        end
      end
      S_AL_RD: begin
        cmd_o.op = OP_AL_RD;
        state_d  = S_AL_UNL;
      end
      S_AL_UNL: begin
        cmd_o.op = OP_UNL_P;
        state_d  = S_AL_SPL;
      end
      S_AL_SPL: begin
        if (stat_i.split_more) begin
          cmd_o.op = OP_SPLIT;
          state_d  = S_PUSH_A;
        end else begin
          cmd_o.op = OP_AL_FIN;
          res_d    = RES_ALLOC;
          state_d  = S_RES;
        end
      end
      S_FR_RD: begin
        if (stat_i.page_oob) begin
          res_d   = RES_ZERO;
          state_d = S_RES;
        end else begin
          cmd_o.op = OP_FR_RD;
          state_d  = S_FR_CHK;
        end
      end
      S_FR_CHK: begin
        cmd_o.op = OP_FR_INIT;
        if (stat_i.rd_free) begin
          res_d   = RES_ORD;
          state_d = S_RES;
        end else begin
          state_d = S_FR_LOOP;
        end
      end
      S_FR_LOOP: begin
        if (stat_i.loop_more) begin
          cmd_o.op = OP_RD_B;
          state_d  = S_FR_BUD;
        end else begin
          state_d = S_PUSH_A;
        end
      end
      S_FR_BUD: begin
        if (stat_i.merge_ok) begin
          cmd_o.op = OP_MERGE;
          state_d  = S_FR_LOOP;
        end else begin
          state_d = S_PUSH_A;
        end
      end
      S_RES: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      span_q  <= 1'b0;
      res_q   <= RES_ZERO;
      mode_q  <= MODE_ADD;
    end else begin
      state_q <= state_d;
      span_q  <= span_d;
      res_q   <= res_d;
      mode_q  <= mode_d;
    end
  end

endmodule

`default_nettype wire

@@ src/bpa_dpath.sv @@
`default_nettype none

module bpa_dpath (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire bpa_pkg::cmd_t                     cmd_i,
  output bpa_pkg::stat_t                         stat_o,
  input  wire logic [bpa_pkg::IN_DATA_W-1:0]     in_data_i,
  input  wire logic [bpa_pkg::MODE_W-1:0]        in_mode_i,
  input  wire logic                              cfg_valid_i,
  input  wire logic [bpa_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [bpa_pkg::OUT_DATA_W-1:0]         out_data_o,
  output logic [bpa_pkg::STATUS_W-1:0]           out_user_o
);
  import bpa_pkg::*;

  // latched item
  logic [MODE_W-1:0] mode_q;
  logic [PAGE_W-1:0] pg_q;
  logic [CFG_W-1:0]  cnt_q;
  logic              rfree_q;
  logic [ORD_W-1:0]  req_q;
  logic              low_q;
  logic [CFG_W-1:0]  lz_end_q;

  // working registers
  logic [SPAN_W-1:0] j_q, e_q, q_q, b_q;
  logic [ORD_W-1:0]  k_q, top_q;
  logic [PAGE_W-1:0] p_q;
  logic              zone_q;
  logic [LINK_W-1:0] heads_q [NUM_LISTS];
  logic [PAGE_W-1:0] clr_q;

  // page table
  logic [LINK_W-1:0] mem_next [NUM_PAGES];
  logic [LINK_W-1:0] mem_prev [NUM_PAGES];
  logic [ORD_W-1:0]  mem_ord  [NUM_PAGES];
  logic [ORD_W-1:0]  mem_top  [NUM_PAGES];
  logic              mem_free [NUM_PAGES];
  logic [LINK_W-1:0] rd_next_q, rd_prev_q;
  logic [ORD_W-1:0]  rd_ord_q, rd_top_q;
  logic              rd_free_q;

  logic                  out_valid_q;
  logic [PAGE_W-1:0]     out_page_q;
  logic [ORD_W-1:0]      out_ord_q;
  logic [STATUS_W-1:0]   out_st_q;

  logic [LIST_W-1:0] head_idx;
  logic [LINK_W-1:0] head_sel;
  logic [TOP_ORDER:0] ne_lo, ne_hi, ne;
  logic              srch_hit;
  logic [ORD_W-1:0]  srch_k;
  logic [SPAN_W-1:0] span_end, lo_hi, lz_ext, pg_ext, s0, e0, s1, e1, rem;
  logic [ORD_W-1:0]  blk_k;
  logic [SPAN_W-1:0] pp;
  logic [PAGE_W-1:0] pp_a;
  logic              push_ok;
  logic              unl;
  logic [PAGE_W-1:0] unl_pg;
  logic [PAGE_W-1:0] mrg_hi;

  logic              nx_we, pv_we, od_we, tp_we, fr_we, fr_wd, rd_en;
  logic [PAGE_W-1:0] nx_wa, pv_wa, od_wa, tp_wa, fr_wa, rd_addr;
  logic [LINK_W-1:0] nx_wd, pv_wd;
  logic [ORD_W-1:0]  od_wd, tp_wd;

  // list heads
  assign head_idx = list_of(zone_q, k_q);
  assign head_sel = heads_q[head_idx];

  always_comb begin
    for (int i = 0; i <= TOP_ORDER; i++) begin
      ne_lo[i] = link_ok(heads_q[i]);
      ne_hi[i] = link_ok(heads_q[TOP_ORDER + 1 + i]);
    end
    ne       = low_q ? ne_lo : ne_hi;
    srch_hit = 1'b0;
    srch_k   = '0;
    // descending so the smallest fitting order wins
    for (int i = TOP_ORDER; i >= 0; i--) begin
      if (ORD_W'(i) >= req_q && ne[i]) begin
        srch_hit = 1'b1;
        srch_k   = ORD_W'(i);
      end
    end
  end

  // zone clipping of an added region
  always_comb begin
    pg_ext   = SPAN_W'(pg_q);
    lz_ext   = SPAN_W'(lz_end_q);
    span_end = pg_ext + SPAN_W'(cnt_q);
    lo_hi    = (lz_ext < SPAN_W'(NUM_PAGES)) ? lz_ext : SPAN_W'(NUM_PAGES);
    s0       = (pg_ext > SPAN_W'(1)) ? pg_ext : SPAN_W'(1);
    e0       = (span_end < lo_hi) ? span_end : lo_hi;
    s1       = (pg_ext > lz_ext) ? pg_ext : lz_ext;
    e1       = (span_end < SPAN_W'(NUM_PAGES)) ? span_end : SPAN_W'(NUM_PAGES);
  end

  // largest aligned block that fits
  always_comb begin
    rem   = e_q - j_q;
    blk_k = '0;
    for (int i = 1; i <= TOP_ORDER; i++) begin
      if (rem >= (SPAN_W'(1) << i) && (j_q & ((SPAN_W'(1) << i) - SPAN_W'(1))) == '0)
        blk_k = ORD_W'(i);
    end
  end

  always_comb begin
    unique case (mode_q)
      MODE_ADD:   pp = j_q;
      MODE_ALLOC: pp = b_q;
      default:    pp = SPAN_W'(p_q);
    endcase
  end
  assign pp_a    = pp[PAGE_W-1:0];
  assign push_ok = pp < SPAN_W'(NUM_PAGES);

  assign unl = (cmd_i.op == OP_PG_WR && rd_free_q) || cmd_i.op == OP_UNL_P ||
               cmd_i.op == OP_MERGE;
  always_comb begin
    unique case (cmd_i.op)
      OP_PG_WR: unl_pg = q_q[PAGE_W-1:0];
      OP_UNL_P: unl_pg = p_q;
      default:  unl_pg = b_q[PAGE_W-1:0];
    endcase
  end
  assign mrg_hi = (b_q[PAGE_W-1:0] > p_q) ? b_q[PAGE_W-1:0] : p_q;

  // memory port steering
  always_comb begin
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
    od_we = 1'b0; od_wa = '0; od_wd = '0;
    tp_we = 1'b0; tp_wa = '0; tp_wd = '0;
    fr_we = 1'b0; fr_wa = '0; fr_wd = 1'b0;
    rd_en = 1'b0; rd_addr = '0;
    if (unl) begin
      if (link_ok(rd_prev_q)) begin
        nx_we = 1'b1;
        nx_wa = rd_prev_q[PAGE_W-1:0];
        nx_wd = rd_next_q;
      end
      if (link_ok(rd_next_q)) begin
        pv_we = 1'b1;
        pv_wa = rd_next_q[PAGE_W-1:0];
        pv_wd = rd_prev_q;
      end
      fr_we = 1'b1;
      fr_wa = unl_pg;
    end
    unique case (cmd_i.op)
      OP_CLEAR: begin
        fr_we = 1'b1;
        fr_wa = clr_q;
      end
      OP_PG_RD: begin
        rd_en   = 1'b1;
        rd_addr = q_q[PAGE_W-1:0];
      end
      OP_PG_WR: begin
        od_we = 1'b1; od_wa = q_q[PAGE_W-1:0]; od_wd = '0;
        tp_we = 1'b1; tp_wa = q_q[PAGE_W-1:0]; tp_wd = k_q;
      end
      OP_PUSH_A: begin
        if (push_ok) begin
          nx_we = 1'b1; nx_wa = pp_a; nx_wd = head_sel;
          if (link_ok(head_sel)) begin
            pv_we = 1'b1;
            pv_wa = head_sel[PAGE_W-1:0];
            pv_wd = LINK_W'(pp_a);
          end
          od_we = 1'b1; od_wa = pp_a; od_wd = k_q;
          fr_we = 1'b1; fr_wa = pp_a; fr_wd = 1'b1;
        end
      end
      OP_PUSH_B: begin
        if (push_ok) begin
          pv_we = 1'b1; pv_wa = pp_a; pv_wd = LINK_NONE;
        end
      end
      OP_AL_RD: begin
        rd_en   = 1'b1;
        rd_addr = head_sel[PAGE_W-1:0];
      end
      OP_AL_FIN: begin
        od_we = 1'b1; od_wa = p_q; od_wd = req_q;
      end
      OP_FR_RD: begin
        rd_en   = 1'b1;
        rd_addr = pg_q;
      end
      OP_RD_B: begin
        rd_en   = 1'b1;
        rd_addr = p_q ^ (PAGE_W'(1) << k_q);
      end
      OP_MERGE: begin
        od_we = 1'b1; od_wa = mrg_hi; od_wd = k_q + ORD_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (nx_we) mem_next[nx_wa] <= nx_wd;
    if (pv_we) mem_prev[pv_wa] <= pv_wd;
    if (od_we) mem_ord[od_wa]  <= od_wd;
    if (tp_we) mem_top[tp_wa]  <= tp_wd;
    if (fr_we) mem_free[fr_wa] <= fr_wd;
    if (rd_en) begin
      rd_next_q <= mem_next[rd_addr];
      rd_prev_q <= mem_prev[rd_addr];
      rd_ord_q  <= mem_ord[rd_addr];
      rd_top_q  <= mem_top[rd_addr];
      rd_free_q <= mem_free[rd_addr];
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        mode_q  <= in_mode_i;
        pg_q    <= in_data_i[15:0];
        cnt_q   <= in_data_i[32:16];
        rfree_q <= in_data_i[33];
        req_q   <= in_data_i[37:34];
        low_q   <= in_data_i[38];
      end
      OP_SPAN0: begin
        j_q <= s0; e_q <= e0; zone_q <= 1'b0;
      end
      OP_SPAN1: begin
        j_q <= s1; e_q <= e1; zone_q <= 1'b1;
      end
      OP_BLK: begin
        k_q <= blk_k;
        q_q <= j_q;
      end
      OP_PG_WR: q_q <= q_q + SPAN_W'(1);
      OP_NXT:   j_q <= j_q + (SPAN_W'(1) << k_q);
      OP_SRCH: begin
        k_q    <= srch_k;
        zone_q <= ~low_q;
      end
      OP_AL_RD: p_q <= head_sel[PAGE_W-1:0];
      OP_SPLIT: begin
        b_q <= SPAN_W'(p_q) + (SPAN_W'(1) << (k_q - ORD_W'(1)));
        k_q <= k_q - ORD_W'(1);
      end
      OP_FR_INIT: begin
        p_q    <= pg_q;
        k_q    <= rd_ord_q;
        top_q  <= rd_top_q;
        zone_q <= (CFG_W'(pg_q) >= lz_end_q);
      end
      OP_RD_B: b_q <= SPAN_W'(p_q ^ (PAGE_W'(1) << k_q));
      OP_MERGE: begin
        k_q <= k_q + ORD_W'(1);
        if (b_q[PAGE_W-1:0] < p_q) begin
          p_q   <= b_q[PAGE_W-1:0];
          top_q <= rd_top_q;
        end
      end
      default: ;
    endcase
  end

  // control state: heads, clear sweep, config, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int h = 0; h < NUM_LISTS; h++) heads_q[h] <= LINK_NONE;
      clr_q       <= '0;
      lz_end_q    <= LZ_END_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) lz_end_q <= cfg_data_i;
      if (cmd_i.op == OP_CLEAR) clr_q <= clr_q + PAGE_W'(1);
      if (unl) begin
        for (int h = 0; h < NUM_LISTS; h++)
          if (heads_q[h] == LINK_W'(unl_pg)) heads_q[h] <= rd_next_q;
      end
      if (cmd_i.op == OP_PUSH_A && push_ok) heads_q[head_idx] <= LINK_W'(pp_a);
      if (cmd_i.op == OP_EMIT)  out_valid_q <= 1'b1;
      else if (out_ready_i)     out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_EMIT) begin
      out_page_q <= '0;
      out_ord_q  <= '0;
      out_st_q   <= ST_OK;
      unique case (cmd_i.res)
        RES_BAD: out_st_q <= ST_BADORD;
        RES_OOM: out_st_q <= ST_NOMEM;
        RES_ALLOC: begin
          out_page_q <= p_q;
          out_ord_q  <= req_q;
        end
        RES_ORD: out_ord_q <= k_q;
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_user_o  = out_st_q;
  assign out_data_o  = {(OUT_DATA_W - PAGE_W - ORD_W)'(0), out_ord_q, out_page_q};

  always_comb begin
    stat_o.clr_last    = (clr_q == PAGE_W'(NUM_PAGES - 1));
    stat_o.blk_more    = (j_q < e_q);
    stat_o.pg_last     = ((q_q + SPAN_W'(1)) == (j_q + (SPAN_W'(1) << k_q)));
    stat_o.rd_free     = rd_free_q;
    stat_o.srch_hit    = srch_hit;
    stat_o.req_bad     = (req_q > ORD_W'(TOP_ORDER));
    stat_o.split_more  = (k_q > req_q);
    stat_o.loop_more   = (k_q < top_q) && (k_q < ORD_W'(TOP_ORDER));
    stat_o.merge_ok    = (b_q < SPAN_W'(NUM_PAGES)) && rd_free_q &&
                         (rd_ord_q != rd_top_q) && (rd_ord_q == k_q);
    stat_o.out_free    = !out_valid_q || out_ready_i;
    stat_o.region_free = rfree_q;
    stat_o.page_oob    = (SPAN_W'(pg_q) >= SPAN_W'(NUM_PAGES));
  end

endmodule

`default_nettype wire

@@ src/bpa_checker.sv @@
`default_nettype none

module bpa_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [bpa_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  input wire logic [bpa_pkg::STATUS_W-1:0]      m_axis_tuser
);
  import bpa_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while busy");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == ST_OK || m_axis_tuser == ST_NOMEM ||
                      m_axis_tuser == ST_BADORD)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == '0)
    else $error("error result carries data");

endmodule

bind buddy_page_allocator_unit bpa_checker u_bpa_checker (.*);

`default_nettype wire
